// ===== rtl/cht_pkg.sv =====
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and constants of the chained hash table.
// ----------------------------------------------------------------------------
package cht_pkg;
  localparam int MAX_BUCKETS = 1024;
  localparam int POOL_NODES = 4096;
  localparam int BW = $clog2(MAX_BUCKETS);
  localparam int NW = $clog2(POOL_NODES);
  localparam int PW = NW + 1;
  localparam int KEY_W = 31;
  localparam int VAL_W = 32;
  localparam int CNT_W = 11;
  localparam int DIV_STEPS = KEY_W;
  localparam int SW = $clog2(DIV_STEPS + 1);
  localparam int WALK_W = NW + 1;
  localparam logic [PW-1:0] NO_NODE = {PW{1'b1}};
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(10);

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_POOL_FULL = 2'd2;

  localparam logic FUNC_INSERT = 1'b0;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_BREAD, S_BWAIT, S_INS, S_NREAD, S_NWAIT, S_CMP, S_OUT
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic div_step;
    logic bucket_rd;
    logic head_load;
    logic ins_write;
    logic node_rd;
    logic node_next;
    logic res_full;
    logic res_miss;
    logic res_hit;
    logic res_ins;
    logic out_valid;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic is_insert;
    logic pool_full;
    logic cur_null;
    logic key_match;
    logic walk_done;
  } stat_t;
endpackage

// ===== rtl/cht_ram.sv =====
// ----------------------------------------------------------------------------
// cht_ram
// Generic single-port-write, registered-read RAM.
// ----------------------------------------------------------------------------
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/cht_ctrl.sv =====
// ----------------------------------------------------------------------------
// cht_ctrl
// Request sequencer: clearing pass, divide, bucket read, insert or walk.
// ----------------------------------------------------------------------------
module cht_ctrl import cht_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_fire,
  input  logic  out_fire,
  input  stat_t st,
  output logic  in_ready,
  output cmd_t  cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (st.clr_done) state_next = S_IDLE;
      S_IDLE:  if (in_fire) state_next = S_DIV;
      S_DIV:   if (st.div_done) state_next = S_BREAD;
      S_BREAD: state_next = S_BWAIT;
      S_BWAIT: begin
        if (st.is_insert) begin
          state_next = st.pool_full ? S_OUT : S_INS;
        end else begin
          state_next = st.cur_null ? S_OUT : S_NREAD;
        end
      end
      S_INS:   state_next = S_OUT;
      S_NREAD: state_next = S_NWAIT;
      S_NWAIT: state_next = S_CMP;
      S_CMP: begin
        if (st.key_match || st.cur_null || st.walk_done) state_next = S_OUT;
        else state_next = S_NREAD;
      end
      S_OUT:   if (out_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_fire;
      end
      S_DIV:   cmd.div_step = 1'b1;
      S_BREAD: cmd.bucket_rd = 1'b1;
      S_BWAIT: begin
        if (st.is_insert) begin
          cmd.res_full = st.pool_full;
        end else begin
          cmd.res_miss = st.cur_null;
          cmd.head_load = !st.cur_null;
        end
      end
      S_INS: begin
        cmd.ins_write = 1'b1;
        cmd.res_ins = 1'b1;
      end
      S_NREAD: cmd.node_rd = 1'b1;
      S_NWAIT: ;
      S_CMP: begin
        cmd.res_hit = st.key_match;
        cmd.node_next = !st.key_match;
      end
      S_OUT:   cmd.out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

// ===== rtl/cht_dp.sv =====
// ----------------------------------------------------------------------------
// cht_dp
// Datapath: restoring divider, bucket and node memories, result register.
// ----------------------------------------------------------------------------
module cht_dp import cht_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  logic [CNT_W-1:0] bucket_count,
  input  logic             func,
  input  logic [KEY_W-1:0] lookup_key,
  input  logic [VAL_W-1:0] entry_value,
  output stat_t            st,
  output logic [VAL_W-1:0] found_value,
  output logic [1:0]       status
);
  logic             op;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] val;
  logic [CNT_W-1:0] divisor;
  logic [KEY_W-1:0] quo;
  logic [CNT_W:0]   rem;
  logic [SW-1:0]    dstep;
  logic [BW:0]      clr_addr;
  logic [NW:0]      nodes_used;
  logic [PW-1:0]    cur;
  logic [WALK_W-1:0] steps;
  logic [CNT_W:0]   trial;
  logic [CNT_W-1:0] eff;

  logic [PW-1:0]    head_rd, tail_rd, link_rd;
  logic [KEY_W-1:0] key_rd;
  logic [VAL_W-1:0] val_rd;
  logic             head_we, tail_we, link_we;
  logic [BW-1:0]    baddr;
  logic [PW-1:0]    head_wd, tail_wd;
  logic [NW-1:0]    link_wa;

  always_comb begin
    if (bucket_count == '0) eff = CNT_W'(1);
    else if (bucket_count > CNT_W'(MAX_BUCKETS)) eff = CNT_W'(MAX_BUCKETS);
    else eff = bucket_count;
  end

  assign trial = {rem[CNT_W-1:0], quo[KEY_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      nodes_used <= '0;
    end else begin
      if (cmd.clr_step) clr_addr <= clr_addr + 1'b1;
      if (cmd.ins_write) nodes_used <= nodes_used + 1'b1;
    end
    if (cmd.load) begin
      op <= func;
      key <= lookup_key;
      val <= entry_value;
      divisor <= eff;
      quo <= lookup_key;
      rem <= '0;
      dstep <= '0;
      steps <= '0;
    end
    if (cmd.div_step) begin
      quo <= {quo[KEY_W-2:0], 1'b0};
      rem <= (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
      dstep <= dstep + 1'b1;
    end
    if (cmd.res_miss || cmd.res_full || cmd.res_ins) found_value <= '1;
    if (cmd.res_miss) status <= ST_NOT_FOUND;
    if (cmd.res_full) status <= ST_POOL_FULL;
    if (cmd.res_ins) status <= ST_OK;
    if (cmd.head_load) cur <= head_rd;
    if (cmd.node_next) begin
      cur <= link_rd;
      steps <= steps + 1'b1;
      found_value <= '1;
      status <= ST_NOT_FOUND;
    end
    if (cmd.res_hit) begin
      found_value <= val_rd;
      status <= ST_OK;
    end
  end

  assign baddr = cmd.clr_step ? clr_addr[BW-1:0] : rem[BW-1:0];
  assign head_we = cmd.clr_step || (cmd.ins_write && tail_rd == NO_NODE);
  assign tail_we = cmd.clr_step || cmd.ins_write;
  assign head_wd = cmd.clr_step ? NO_NODE : {1'b0, nodes_used[NW-1:0]};
  assign tail_wd = head_wd;
  assign link_we = cmd.ins_write;
  assign link_wa = nodes_used[NW-1:0];

  logic          plink_we;
  assign plink_we = cmd.ins_write && tail_rd != NO_NODE;

  cht_ram #(.WIDTH(PW), .DEPTH(MAX_BUCKETS)) u_head (
    .clk(clk), .we(head_we), .waddr(baddr), .wdata(head_wd),
    .raddr(baddr), .rdata(head_rd));
  cht_ram #(.WIDTH(PW), .DEPTH(MAX_BUCKETS)) u_tail (
    .clk(clk), .we(tail_we), .waddr(baddr), .wdata(tail_wd),
    .raddr(baddr), .rdata(tail_rd));
  cht_ram #(.WIDTH(KEY_W), .DEPTH(POOL_NODES)) u_key (
    .clk(clk), .we(link_we), .waddr(link_wa), .wdata(key),
    .raddr(cur[NW-1:0]), .rdata(key_rd));
  cht_ram #(.WIDTH(VAL_W), .DEPTH(POOL_NODES)) u_val (
    .clk(clk), .we(link_we), .waddr(link_wa), .wdata(val),
    .raddr(cur[NW-1:0]), .rdata(val_rd));
  // The new node's own link and the old tail's link are written in separate
  // cycles; the first goes in the insert cycle, the second in the cycle after it.
  logic          tl_pend;
  logic [NW-1:0] tl_addr;
  logic [NW-1:0] tl_node;
  always_ff @(posedge clk) begin
    if (rst) tl_pend <= 1'b0;
    else tl_pend <= plink_we;
    tl_addr <= tail_rd[NW-1:0];
    tl_node <= nodes_used[NW-1:0];
  end
  cht_ram #(.WIDTH(PW), .DEPTH(POOL_NODES)) u_link (
    .clk(clk), .we(link_we || tl_pend),
    .waddr(tl_pend ? tl_addr : link_wa),
    .wdata(tl_pend ? {1'b0, tl_node} : NO_NODE),
    .raddr(cur[NW-1:0]), .rdata(link_rd));

  assign st.clr_done = clr_addr[BW-1:0] == BW'(MAX_BUCKETS - 1);
  assign st.div_done = dstep == SW'(DIV_STEPS - 1);
  assign st.is_insert = op == FUNC_INSERT;
  assign st.pool_full = nodes_used == (NW+1)'(POOL_NODES);
  assign st.cur_null = head_rd == NO_NODE;
  assign st.key_match = key_rd == key;
  assign st.walk_done = steps == WALK_W'(POOL_NODES - 1) || link_rd == NO_NODE;
endmodule

// ===== rtl/chained_hash_table.sv =====
// ----------------------------------------------------------------------------
// chained_hash_table
// Hash table with separate chaining over a bounded node pool.
// ----------------------------------------------------------------------------
// Requests arrive as words on the s_axis channel: an insert (func 0) or a
// lookup (func 1). Each request gives one result word on m_axis.
// The bucket is the key modulo bucket_count, written on the cfg channel;
// a count of 0 is taken as 1, and one above 1024 as 1024. One request is
// in flight at a time. A request passes an accept state, the divider and
// a bucket memory read and wait, then an insert write (skipped when the
// pool is full), or on a lookup a node read, wait and compare for each
// chain node visited (none when the bucket is empty), then the output state.
// After reset a clearing pass over the 1024 buckets empties their memories;
// s_axis_tready stays low until it ends. cfg writes are taken at any time.
// The result waits in its register while m_axis_tready is low; no new
// request is taken until it has been delivered.
// ----------------------------------------------------------------------------
module chained_hash_table import cht_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // lookup_key[30:0], entry_value[62:31], zero
  input  logic        s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // found_value[31:0], status[33:32], zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);
  logic [CNT_W-1:0] bucket_count;
  cmd_t             cmd;
  stat_t            st;
  logic [VAL_W-1:0] found_value;
  logic [1:0]       status;
  logic             in_fire;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) bucket_count <= CNT_RESET;
    else if (cfg_valid) bucket_count <= cfg_data;
  end

  assign in_fire = s_axis_tvalid && s_axis_tready;

  cht_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire),
    .out_fire(m_axis_tvalid && m_axis_tready),
    .st(st), .in_ready(s_axis_tready), .cmd(cmd));

  cht_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .bucket_count(bucket_count),
    .func(s_axis_tuser), .lookup_key(s_axis_tdata[30:0]),
    .entry_value(s_axis_tdata[62:31]), .st(st),
    .found_value(found_value), .status(status));

  assign m_axis_tvalid = cmd.out_valid;
  assign m_axis_tdata = {6'd0, status, found_value};
endmodule

// ===== sim/cht_checker.sv =====
// ----------------------------------------------------------------------------
// cht_checker
// Watches the request, result and cfg channels of the chained hash table,
// keeps its own copy of the table, and checks every result word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module cht_checker import cht_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // lookup_key[30:0], entry_value[62:31], zero
  input  logic        s_axis_tuser,  // func
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,  // found_value[31:0], status[33:32], zero
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [10:0] cfg_data,
  output int          pending,
  output int          fails
);
  typedef struct packed {
    logic [VAL_W-1:0] found;
    logic [1:0]       status;
  } answer_t;

  logic [PW-1:0]    chain_head [MAX_BUCKETS];
  logic [PW-1:0]    chain_tail [MAX_BUCKETS];
  logic [KEY_W-1:0] slot_key   [POOL_NODES];
  logic [VAL_W-1:0] slot_val   [POOL_NODES];
  logic [PW-1:0]    slot_next  [POOL_NODES];
  int               slots_taken;
  logic [CNT_W-1:0] divisor;
  answer_t          answers [$];
  int               fail_cnt;

  task automatic report(input string what, input logic [39:0] got, input logic [39:0] want);
    $display("%0t mismatch: %s got %h expected %h", $realtime, what, got, want);
    fail_cnt++;
  endtask

  function automatic answer_t table_access(input logic op, input logic [KEY_W-1:0] key,
                                           input logic [VAL_W-1:0] val);
    int      nb;
    int      b;
    int      cur;
    int      steps;
    answer_t a;
    nb = (divisor == 0) ? 1 : (divisor > MAX_BUCKETS) ? MAX_BUCKETS : divisor;
    b = int'(key) % nb;
    a.found = '1;
    if (op == FUNC_INSERT) begin
      if (slots_taken >= POOL_NODES) begin
        a.status = ST_POOL_FULL;
      end else begin
        slot_key[slots_taken] = key;
        slot_val[slots_taken] = val;
        slot_next[slots_taken] = NO_NODE;
        if (chain_tail[b] == NO_NODE) begin
          chain_head[b] = PW'(slots_taken);
        end else begin
          slot_next[chain_tail[b]] = PW'(slots_taken);
        end
        chain_tail[b] = PW'(slots_taken);
        slots_taken++;
        a.status = ST_OK;
      end
    end else begin
      a.status = ST_NOT_FOUND;
      cur = (chain_head[b] == NO_NODE) ? -1 : int'(chain_head[b]);
      steps = 0;
      while (cur >= 0 && steps < POOL_NODES) begin
        if (slot_key[cur] == key) begin
          a.found = slot_val[cur];
          a.status = ST_OK;
          break;
        end
        cur = (slot_next[cur] == NO_NODE) ? -1 : int'(slot_next[cur]);
        steps++;
      end
    end
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      for (int i = 0; i < MAX_BUCKETS; i++) begin
        chain_head[i] = NO_NODE;
        chain_tail[i] = NO_NODE;
      end
      slots_taken = 0;
      divisor = CNT_RESET;
      answers.delete();
      fail_cnt = 0;
    end else begin
      if (cfg_valid && cfg_ready) divisor = cfg_data;
      if (m_axis_tvalid && m_axis_tready) begin
        if (answers.size() == 0) begin
          report("unexpected word", m_axis_tdata, '0);
        end else begin
          want = answers.pop_front();
          if (m_axis_tdata[31:0] !== want.found)
            report("found_value", m_axis_tdata[31:0], want.found);
          if (m_axis_tdata[33:32] !== want.status)
            report("status", m_axis_tdata[33:32], want.status);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        answers.push_back(table_access(s_axis_tuser, s_axis_tdata[30:0], s_axis_tdata[62:31]));
    end
    pending <= answers.size();
    fails <= fail_cnt;
  end
endmodule

// ===== sim/tb_chained_hash_table.sv =====
// ----------------------------------------------------------------------------
// tb_chained_hash_table
// Drives inserts and lookups into the chained hash table over several bucket
// counts, with random idling on both sides, and reports the checker verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_chained_hash_table import cht_pkg::*; ();
  localparam logic FUNC_LOOKUP = 1'b1;
  localparam int   STALL_LIMIT = 60000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;
  int          pending;
  int          fails;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          quiet = 0;
  logic [KEY_W-1:0] known_keys [256];
  int          known_cnt = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  chained_hash_table u_dut (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid, .cfg_ready, .cfg_data
  );

  cht_checker u_check (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid, .cfg_ready, .cfg_data,
    .pending, .fails
  );

  always @(posedge clk) begin
    m_axis_tready <= !rst && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_word(input logic op, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] val);
    logic hit;
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {1'b0, val, key};
    do begin
      @(negedge clk);
      hit = s_axis_tready;
      @(posedge clk);
    end while (!hit);
    if (op == FUNC_INSERT) begin
      known_keys[known_cnt % 256] = key;
      known_cnt++;
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_count(input logic [10:0] value);
    logic hit;
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do begin
      @(negedge clk);
      hit = cfg_ready;
      @(posedge clk);
    end while (!hit);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 45 && known_cnt > 0) return known_keys[$urandom_range(
        (known_cnt < 256 ? known_cnt : 256) - 1)];
    if (r < 65) return KEY_W'($urandom_range(60));
    if (r < 72) return {KEY_W{1'b1}} - KEY_W'($urandom_range(3));
    return KEY_W'($urandom);
  endfunction

  task automatic random_words(input int n, input bit hold_off);
    for (int i = 0; i < n; i++) begin
      if (hold_off && i == n / 2) drain();
      send_word($urandom_range(1) ? FUNC_LOOKUP : FUNC_INSERT, pick_key(), $urandom);
    end
  endtask

  initial begin
    logic [10:0] counts [6];
    int          sizes [6];
    counts = '{11'd1024, 11'd3, 11'd2047, 11'd0, 11'd1, 11'd7};
    sizes = '{300, 300, 300, 60, 50, 300};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    send_idle = 28;
    recv_idle = 50;
    send_word(FUNC_LOOKUP, 31'd5, 32'd0);
    send_word(FUNC_INSERT, 31'd0, 32'h8000_0000);
    send_word(FUNC_INSERT, 31'h7fff_ffff, 32'h7fff_ffff);
    send_word(FUNC_INSERT, 31'd10, 32'd1);
    send_word(FUNC_INSERT, 31'd0, 32'd2);
    send_word(FUNC_LOOKUP, 31'd0, 32'hffff_ffff);
    send_word(FUNC_LOOKUP, 31'd10, 32'd0);
    send_word(FUNC_LOOKUP, 31'd20, 32'd0);
    send_word(FUNC_LOOKUP, 31'h7fff_ffff, 32'h5555_aaaa);
    send_word(FUNC_INSERT, 31'h2aaa_aaaa, 32'hffff_ffff);
    send_word(FUNC_INSERT, 31'h5555_5555, 32'h0000_0000);
    send_word(FUNC_LOOKUP, 31'h5555_5555, 32'd0);
    write_count(11'd1);
    send_word(FUNC_LOOKUP, 31'h7fff_ffff, 32'd0);
    send_word(FUNC_LOOKUP, 31'd10, 32'd0);
    send_word(FUNC_INSERT, 31'd3, 32'd3);
    send_word(FUNC_LOOKUP, 31'd3, 32'd0);
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle = 50;
        recv_idle = 28;
      end else if (p == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_count(p == 4 ? 11'($urandom_range(1024, 1)) : counts[p]);
      random_words(sizes[p], p == 1);
    end
    write_count(11'd1024);
    send_idle = 10;
    recv_idle = 10;
    for (int i = 0; i < 20; i++) begin
      send_word(i % 2 ? FUNC_LOOKUP : FUNC_INSERT, pick_key(), $urandom);
    end
    drain();
    repeat (50) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== chained_hash_table.f =====
rtl/cht_pkg.sv
rtl/cht_ram.sv
rtl/cht_ctrl.sv
rtl/cht_dp.sv
rtl/chained_hash_table.sv
sim/cht_checker.sv
sim/tb_chained_hash_table.sv
